### rtl/core/plcc_pkg.sv
package plcc_pkg;

    localparam int PIX_W  = 8;
    localparam int OFS_W  = 9;
    localparam int CIDX_W = 3;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] GREY_MID = 8'd127;
    localparam logic [PIX_W-1:0] DARK_Q1  = 8'd64;
    localparam logic [PIX_W-1:0] DARK_Q2  = 8'd128;

    localparam logic [CIDX_W-1:0] REG_FLAT_EN  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GREY_EN  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_DARK_EN  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BLACK_OF = 3'd3;
    localparam logic [CIDX_W-1:0] REG_SHADE_OF = 3'd4;

    typedef struct packed {
        logic [PIX_W-1:0] sample;
        logic [PIX_W-1:0] black_ref;
        logic [PIX_W-1:0] shade_ref;
        logic [PIX_W-1:0] grey_ref;
        logic [PIX_W-1:0] dark_ref;
        logic             frame_end;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] corrected;
        logic             frame_end_out;
    } t_out_word;

    typedef struct packed {
        logic                    flat_enable;
        logic                    grey_enable;
        logic                    dark_enable;
        logic signed [OFS_W-1:0] black_offset;
        logic signed [OFS_W-1:0] shade_offset;
    } t_cfg;

    // per-pixel fields carried along the chain
    typedef struct packed {
        logic [PIX_W-1:0] grey_ref;
        logic [PIX_W-1:0] dark_ref;
        logic             frame_end;
    } t_side;

endpackage

### rtl/core/plcc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient saturates to all ones when it would not fit in QW bits.
module plcc_div #(
    parameter int NW = 17,
    parameter int DW = 10,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int LW = NW + DW + QW;

    logic          r_vld  [QW+1];
    logic [NW-1:0] r_rem  [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic [QW-1:0] r_quo  [QW+1];
    logic          r_sat  [QW+1];
    logic [SW-1:0] r_side [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_sat[0]  <= LW'(i_num) >= (LW'(i_den) << QW);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [LW-1:0] w_sh;
        logic          w_ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            w_sh  = LW'(r_den[k-1]) << B;
            w_ge  = LW'(r_rem[k-1]) >= w_sh;
            n_rem = w_ge ? NW'(LW'(r_rem[k-1]) - w_sh) : r_rem[k-1];
            n_quo = r_quo[k-1];
            n_quo[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= r_den[k-1];
                r_quo[k]  <= n_quo;
                r_sat[k]  <= r_sat[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_sat[QW] ? '1 : r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

### rtl/core/plcc_flat.sv
// Black/shading flat field: (v-bk)*255 / max(1, sh-bk), clamped 0..255; bypassed when disabled.
module plcc_flat (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  plcc_pkg::t_in_word        i_word,
    input  plcc_pkg::t_cfg            i_cfg,
    output logic                      o_valid,
    output logic [plcc_pkg::PIX_W-1:0] o_val,
    output plcc_pkg::t_side           o_side
);

    typedef struct packed {
        logic [plcc_pkg::PIX_W-1:0] c;
        logic                       byp;
        logic                       zero;
        plcc_pkg::t_side            side;
    } t_fctl;

    logic signed [10:0] w_bk, w_sh, w_span, w_diff;
    logic [16:0]        n_num;
    logic [9:0]         n_den;
    t_fctl              n_ctl;

    logic        r_vld;
    logic [16:0] r_num;
    logic [9:0]  r_den;
    t_fctl       r_ctl;

    logic                       d_vld;
    logic [7:0]                 d_quo;
    t_fctl                      d_ctl;

    logic                       r_ovld;
    logic [plcc_pkg::PIX_W-1:0] r_oval;
    plcc_pkg::t_side            r_oside;

    always_comb begin
        w_bk   = signed'({3'b000, i_word.black_ref}) + 11'(i_cfg.black_offset);
        w_sh   = signed'({3'b000, i_word.shade_ref}) + 11'(i_cfg.shade_offset);
        w_span = w_sh - w_bk;
        w_diff = signed'({3'b000, i_word.sample}) - w_bk;
        // diff*255 as diff*256 - diff; only used when diff is non-negative
        n_num  = (17'(unsigned'(w_diff)) << 8) - 17'(unsigned'(w_diff));
        n_den  = (w_span < 11'sd1) ? 10'd1 : unsigned'(w_span[9:0]);
        n_ctl.c    = i_word.sample;
        n_ctl.byp  = !i_cfg.flat_enable;
        n_ctl.zero = w_diff[10];
        n_ctl.side.grey_ref  = i_word.grey_ref;
        n_ctl.side.dark_ref  = i_word.dark_ref;
        n_ctl.side.frame_end = i_word.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_ctl <= n_ctl;
        end
    end

    plcc_div #(.NW(17), .DW(10), .QW(8), .SW($bits(t_fctl))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_ctl),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= d_vld;
        end
        if (i_en) begin
            r_oval  <= d_ctl.byp ? d_ctl.c : (d_ctl.zero ? '0 : d_quo);
            r_oside <= d_ctl.side;
        end
    end

    assign o_valid = r_ovld;
    assign o_val   = r_oval;
    assign o_side  = r_oside;

endmodule

### rtl/core/plcc_grey.sv
// Grey-level two-segment remap about 127; bypassed when disabled or when grey_ref is 0 or 127.
module plcc_grey (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [plcc_pkg::PIX_W-1:0] i_val,
    input  plcc_pkg::t_side            i_side,
    input  logic                       i_enable,
    output logic                       o_valid,
    output logic [plcc_pkg::PIX_W-1:0] o_val,
    output plcc_pkg::t_side            o_side
);

    typedef struct packed {
        logic [plcc_pkg::PIX_W-1:0] c;
        logic                       byp;
        logic                       hi;
        plcc_pkg::t_side            side;
    } t_gctl;

    logic [7:0]  w_g, w_c, w_diff;
    logic        w_lo;
    logic [14:0] n_num;
    logic [7:0]  n_den;
    t_gctl       n_ctl;

    logic        r_vld;
    logic [14:0] r_num;
    logic [7:0]  r_den;
    t_gctl       r_ctl;

    logic       d_vld;
    logic [7:0] d_quo;
    t_gctl      d_ctl;
    logic [8:0] w_sum;

    logic                       r_ovld;
    logic [plcc_pkg::PIX_W-1:0] r_oval;
    plcc_pkg::t_side            r_oside;

    always_comb begin
        w_g    = i_side.grey_ref;
        w_c    = i_val;
        w_lo   = w_g < plcc_pkg::GREY_MID;
        w_diff = w_c - w_g;
        n_ctl.c    = w_c;
        n_ctl.hi   = w_c > w_g;
        n_ctl.byp  = !i_enable || (w_g == '0) || (w_g == plcc_pkg::GREY_MID);
        n_ctl.side = i_side;
        if (n_ctl.hi) begin
            n_num = w_lo ? (15'(w_diff) << 7) : (15'(w_diff) << 7) - 15'(w_diff);
            n_den = plcc_pkg::PIX_MAX - w_g;
        end else begin
            n_num = w_lo ? (15'(w_c) << 7) - 15'(w_c) : (15'(w_c) << 7);
            n_den = w_g;
        end
        if (n_ctl.byp) begin
            n_den = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_ctl <= n_ctl;
        end
    end

    plcc_div #(.NW(15), .DW(8), .QW(8), .SW($bits(t_gctl))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_ctl),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_ctl)
    );

    assign w_sum = (d_ctl.hi ? 9'(plcc_pkg::GREY_MID) : 9'd0) + 9'(d_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= d_vld;
        end
        if (i_en) begin
            if (d_ctl.byp) begin
                r_oval <= d_ctl.c;
            end else begin
                r_oval <= w_sum[8] ? plcc_pkg::PIX_MAX : w_sum[7:0];
            end
            r_oside <= d_ctl.side;
        end
    end

    assign o_valid = r_ovld;
    assign o_val   = r_oval;
    assign o_side  = r_oside;

endmodule

### rtl/core/plcc_dark.sv
// Dark-level remap about 64 and 128; averages with its input for mid references.
module plcc_dark (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [plcc_pkg::PIX_W-1:0] i_val,
    input  plcc_pkg::t_side            i_side,
    input  logic                       i_enable,
    output logic                       o_valid,
    output plcc_pkg::t_out_word        o_word
);

    typedef enum logic [1:0] {DK_PASS, DK_CLAMP, DK_AVG} t_mode;

    typedef struct packed {
        logic [plcc_pkg::PIX_W-1:0] c;
        t_mode                      mode;
        logic                       hi;
        logic                       frame_end;
    } t_dctl;

    logic [7:0]  w_d, w_c;
    logic [13:0] n_num;
    logic [6:0]  n_den;
    t_dctl       n_ctl;

    logic        r_vld;
    logic [13:0] r_num;
    logic [6:0]  r_den;
    t_dctl       r_ctl;

    logic       d_vld;
    logic [8:0] d_quo;
    t_dctl      d_ctl;
    logic [9:0] w_t;
    logic [10:0] w_avg;

    logic                r_ovld;
    plcc_pkg::t_out_word r_oword;

    always_comb begin
        w_d = i_side.dark_ref;
        w_c = i_val;
        n_ctl.c         = w_c;
        n_ctl.frame_end = i_side.frame_end;
        n_ctl.hi        = w_c > w_d;
        n_ctl.mode      = DK_PASS;
        if (i_enable && (w_d != '0)) begin
            if (w_d < plcc_pkg::DARK_Q1) begin
                if (n_ctl.hi && (w_c < plcc_pkg::DARK_Q2)) begin
                    n_ctl.mode = DK_CLAMP;
                end else if (w_c < plcc_pkg::DARK_Q1) begin
                    n_ctl.mode = DK_CLAMP;
                    n_ctl.hi   = 1'b0;
                end
            end else if ((w_d > plcc_pkg::DARK_Q1) && (w_d < plcc_pkg::DARK_Q2)) begin
                n_ctl.mode = DK_AVG;
            end
        end
        if (n_ctl.hi) begin
            n_num = 14'(w_c - w_d) << 6;
            n_den = 7'(plcc_pkg::DARK_Q2 - w_d);
        end else begin
            n_num = 14'(w_c) << 6;
            n_den = w_d[6:0];
        end
        if (n_ctl.mode == DK_PASS) begin
            n_den = 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_ctl <= n_ctl;
        end
    end

    // 9-bit quotient: saturation only happens where the result clamps anyway
    plcc_div #(.NW(14), .DW(7), .QW(9), .SW($bits(t_dctl))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_ctl),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_ctl)
    );

    always_comb begin
        w_t   = (d_ctl.hi ? 10'(plcc_pkg::DARK_Q1) : 10'd0) + 10'(d_quo);
        w_avg = (11'(d_ctl.c) + 11'(w_t)) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= d_vld;
        end
        if (i_en) begin
            case (d_ctl.mode)
                DK_CLAMP: r_oword.corrected <= (w_t > 10'd255) ? plcc_pkg::PIX_MAX : w_t[7:0];
                DK_AVG:   r_oword.corrected <= (w_avg > 11'd255) ? plcc_pkg::PIX_MAX
                                                                : w_avg[7:0];
                default:  r_oword.corrected <= d_ctl.c;
            endcase
            r_oword.frame_end_out <= d_ctl.frame_end;
        end
    end

    assign o_valid = r_ovld;
    assign o_word  = r_oword;

endmodule

### rtl/core/pixel_level_correction_chain_unit.sv
// Channel   Signals                                   Direction
// input     i_valid / o_stall / i_word                 in
// output    o_valid / i_stall / o_word                 out
// config    i_cfg_valid / o_cfg_ready / index, data    in
//
// One word per cycle while the output is not stalled: flat, grey and dark stages
// each take a setup register, a 8 or 9 step divider pipeline and a result register.
// Reset clears the valid bits and the config registers (all stages bypassed).
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
module pixel_level_correction_chain_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  plcc_pkg::t_in_word                i_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output plcc_pkg::t_out_word               o_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [plcc_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [plcc_pkg::OFS_W-1:0]        i_cfg_data
);

    plcc_pkg::t_cfg r_cfg;
    logic           w_adv;

    logic                       f_vld, g_vld;
    logic [plcc_pkg::PIX_W-1:0] f_val, g_val;
    plcc_pkg::t_side            f_side, g_side;

    assign o_cfg_ready = 1'b1;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                plcc_pkg::REG_FLAT_EN:  r_cfg.flat_enable  <= i_cfg_data[0];
                plcc_pkg::REG_GREY_EN:  r_cfg.grey_enable  <= i_cfg_data[0];
                plcc_pkg::REG_DARK_EN:  r_cfg.dark_enable  <= i_cfg_data[0];
                plcc_pkg::REG_BLACK_OF: r_cfg.black_offset <= signed'(i_cfg_data);
                plcc_pkg::REG_SHADE_OF: r_cfg.shade_offset <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    plcc_flat u_flat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_word  (i_word),
        .i_cfg   (r_cfg),
        .o_valid (f_vld),
        .o_val   (f_val),
        .o_side  (f_side)
    );

    plcc_grey u_grey (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (f_vld),
        .i_val    (f_val),
        .i_side   (f_side),
        .i_enable (r_cfg.grey_enable),
        .o_valid  (g_vld),
        .o_val    (g_val),
        .o_side   (g_side)
    );

    plcc_dark u_dark (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (g_vld),
        .i_val    (g_val),
        .i_side   (g_side),
        .i_enable (r_cfg.dark_enable),
        .o_valid  (o_valid),
        .o_word   (o_word)
    );

endmodule
